@@ rtl/mcdt_pkg.sv @@
package mcdt_pkg;

    localparam logic [1:0] OP_TICK       = 2'd0;
    localparam logic [1:0] OP_SET        = 2'd1;
    localparam logic [1:0] OP_GET        = 2'd2;
    localparam logic [1:0] OP_CANCEL_ALL = 2'd3;

    localparam logic [1:0] KIND_DONE     = 2'd0;
    localparam logic [1:0] KIND_EXPIRED  = 2'd1;
    localparam logic [1:0] KIND_READ     = 2'd2;
    localparam logic [1:0] KIND_REJECTED = 2'd3;

    localparam int ID_W      = 4;
    localparam int FIELD_W   = 24;
    localparam int ELAPSED_W = 16;
    localparam int MS_W      = 10;
    // remainder plus elapsed fits in 17 bits; whole seconds fit in 7
    localparam int SUM_W     = 17;
    localparam int DEC_W     = 7;

    localparam logic [SUM_W-1:0] MS_PER_SECOND = 17'd1000;
    // ceil(2^27 / 1000): exact quotient for every sum below 2^17
    localparam int               RECIP_SHIFT   = 27;
    localparam logic [17:0]      RECIP_1000    = 18'd134218;
    localparam int               PROD_W        = SUM_W + 18;

    typedef struct packed {
        logic             done;
        logic [DEC_W-1:0] dec;
        logic [MS_W-1:0]  rem;
    } div_res_t;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_SCAN = 4'b0100,
        S_GET  = 4'b1000
    } state_t;

endpackage

@@ rtl/mcdt_mem.sv @@
module mcdt_mem #(
    parameter int DEPTH = 6,
    parameter int WIDTH = 24,
    parameter int AW    = 3
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/mcdt_div.sv @@
module mcdt_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              go,
    input  logic [mcdt_pkg::MS_W-1:0]         ms_rem,
    input  logic [mcdt_pkg::ELAPSED_W-1:0]    elapsed,
    output mcdt_pkg::div_res_t                res
);

    logic                             s1_vld_reg, s2_vld_reg, s3_vld_reg;
    logic [mcdt_pkg::SUM_W-1:0]       sum_reg;
    logic [mcdt_pkg::DEC_W-1:0]       q_reg;
    logic [mcdt_pkg::MS_W-1:0]        rem_reg;
    logic [mcdt_pkg::PROD_W-1:0]      prod;
    logic [mcdt_pkg::SUM_W-1:0]       q_times;
    logic [mcdt_pkg::SUM_W-1:0]       rem_full;

    // divide by 1000 through the reciprocal
    assign prod     = mcdt_pkg::PROD_W'(sum_reg) * mcdt_pkg::PROD_W'(mcdt_pkg::RECIP_1000);
    assign q_times  = mcdt_pkg::SUM_W'(q_reg) * mcdt_pkg::MS_PER_SECOND;
    assign rem_full = sum_reg - q_times;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= go;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            sum_reg <= mcdt_pkg::SUM_W'(ms_rem) + mcdt_pkg::SUM_W'(elapsed);
        end
        if (s1_vld_reg)
        begin
            q_reg <= prod[mcdt_pkg::RECIP_SHIFT +: mcdt_pkg::DEC_W];
        end
        if (s2_vld_reg)
        begin
            rem_reg <= rem_full[mcdt_pkg::MS_W-1:0];
        end
    end

    assign res.done = s3_vld_reg;
    assign res.dec  = q_reg;
    assign res.rem  = rem_reg;

endmodule

@@ rtl/multi_channel_countdown_timer_top.sv @@
// Countdown timer bank: one seconds counter per channel (1..CHANNELS) in a
// one-port-read, one-port-write RAM, plus a millisecond remainder. Raise start
// with an operation while busy is low. A set, a cancel-all or a rejected id
// answers straight from idle, a get after one read of the RAM. A tick adds the
// elapsed time to the remainder and splits it into whole seconds and a new
// remainder, and reports without a sweep when less than a second has gathered;
// otherwise the RAM is swept one channel per cycle. Each result is shown for
// exactly one cycle with strobe high and cannot be held off; expiries come out
// in ascending channel order and last marks the final result.
module multi_channel_countdown_timer_top #(
    parameter int CHANNELS      = 6,
    parameter int SECONDS_WIDTH = 24
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [1:0]                           operation,
    input  logic [mcdt_pkg::ID_W-1:0]            chan_id,
    input  logic [mcdt_pkg::FIELD_W-1:0]         seconds,
    input  logic [mcdt_pkg::ELAPSED_W-1:0]       tick_ms,
    output logic                                 strobe,
    output logic [1:0]                           kind,
    output logic [mcdt_pkg::ID_W-1:0]            channel,
    output logic [mcdt_pkg::FIELD_W-1:0]         value,
    output logic                                 last
);

    localparam int IW = $clog2(CHANNELS > 1 ? CHANNELS : 2);
    localparam int CW = $clog2(CHANNELS + 1) > IW ? $clog2(CHANNELS + 1) : IW;
    localparam logic [32:0] CMAX = (33'd1 << SECONDS_WIDTH) - 33'd1;
    localparam logic [CW-1:0] LAST_ISS = CW'(CHANNELS);

    mcdt_pkg::state_t state_reg, state_next;

    logic [CHANNELS-1:0]          valid_reg, valid_next;
    logic [mcdt_pkg::MS_W-1:0]    ms_rem_reg, ms_rem_next;
    logic [mcdt_pkg::DEC_W-1:0]   dec_reg, dec_next;
    logic [mcdt_pkg::ID_W-1:0]    id_reg, id_next;
    logic [CW-1:0]                iss_reg, iss_next;
    logic                         proc_vld_reg, proc_vld_next;
    logic [IW-1:0]                proc_idx_reg, proc_idx_next;
    logic                         pend_vld_reg, pend_vld_next;
    logic [mcdt_pkg::ID_W-1:0]    pend_chan_reg, pend_chan_next;

    logic                         strobe_reg, strobe_next;
    logic [1:0]                   kind_reg, kind_next;
    logic [mcdt_pkg::ID_W-1:0]    channel_reg, channel_next;
    logic [mcdt_pkg::FIELD_W-1:0] value_reg, value_next;
    logic                         last_reg, last_next;

    logic                         mem_we;
    logic [IW-1:0]                mem_waddr, mem_raddr;
    logic [SECONDS_WIDTH-1:0]     mem_wdata, mem_rdata;

    logic                         div_go;
    mcdt_pkg::div_res_t           div_res;

    logic                         accept;
    logic                         id_ok;
    logic [IW-1:0]                id_idx, id_reg_idx;
    logic [31:0]                  secs_wide;
    logic [SECONDS_WIDTH-1:0]     secs_sat;
    logic [31:0]                  rd_wide;
    logic [SECONDS_WIDTH-1:0]     dec_ext;

    assign accept     = start && (state_reg == mcdt_pkg::S_IDLE);
    assign id_ok      = (chan_id != '0) && (chan_id <= mcdt_pkg::ID_W'(CHANNELS));
    assign id_idx     = IW'(chan_id - mcdt_pkg::ID_W'(1));
    assign id_reg_idx = IW'(id_reg - mcdt_pkg::ID_W'(1));
    assign secs_wide  = 32'(seconds);
    assign secs_sat   = (33'(seconds) > CMAX) ? CMAX[SECONDS_WIDTH-1:0]
                                              : secs_wide[SECONDS_WIDTH-1:0];
    assign rd_wide    = 32'(mem_rdata);
    assign dec_ext    = SECONDS_WIDTH'(dec_reg);
    assign div_go     = accept && (operation == mcdt_pkg::OP_TICK);

    mcdt_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (div_go),
        .ms_rem  (ms_rem_reg),
        .elapsed (tick_ms),
        .res     (div_res)
    );

    mcdt_mem #(
        .DEPTH (CHANNELS),
        .WIDTH (SECONDS_WIDTH),
        .AW    (IW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        ms_rem_next    = ms_rem_reg;
        dec_next       = dec_reg;
        id_next        = id_reg;
        iss_next       = iss_reg;
        proc_vld_next  = 1'b0;
        proc_idx_next  = proc_idx_reg;
        pend_vld_next  = pend_vld_reg;
        pend_chan_next = pend_chan_reg;
        strobe_next    = 1'b0;
        kind_next      = mcdt_pkg::KIND_DONE;
        channel_next   = '0;
        value_next     = '0;
        last_next      = 1'b1;
        mem_we         = 1'b0;
        mem_waddr      = id_idx;
        mem_wdata      = secs_sat;
        mem_raddr      = id_idx;

        case (state_reg)
            mcdt_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    id_next = chan_id;
                    case (operation)
                        mcdt_pkg::OP_TICK:
                        begin
                            state_next = mcdt_pkg::S_DIV;
                        end
                        mcdt_pkg::OP_SET:
                        begin
                            strobe_next  = 1'b1;
                            channel_next = chan_id;
                            if (id_ok)
                            begin
                                mem_we             = 1'b1;
                                valid_next[id_idx] = (secs_sat != '0);
                            end
                            else
                            begin
                                kind_next = mcdt_pkg::KIND_REJECTED;
                            end
                        end
                        mcdt_pkg::OP_GET:
                        begin
                            if (id_ok)
                            begin
                                state_next = mcdt_pkg::S_GET;
                            end
                            else
                            begin
                                strobe_next  = 1'b1;
                                kind_next    = mcdt_pkg::KIND_REJECTED;
                                channel_next = chan_id;
                            end
                        end
                        mcdt_pkg::OP_CANCEL_ALL:
                        begin
                            valid_next  = '0;
                            strobe_next = 1'b1;
                        end
                        default:
                        begin
                            state_next = mcdt_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            mcdt_pkg::S_GET:
            begin
                strobe_next  = 1'b1;
                kind_next    = mcdt_pkg::KIND_READ;
                channel_next = id_reg;
                value_next   = valid_reg[id_reg_idx] ? rd_wide[mcdt_pkg::FIELD_W-1:0] : '0;
                state_next   = mcdt_pkg::S_IDLE;
            end

            mcdt_pkg::S_DIV:
            begin
                if (div_res.done)
                begin
                    ms_rem_next   = div_res.rem;
                    dec_next      = div_res.dec;
                    iss_next      = '0;
                    pend_vld_next = 1'b0;
                    if (div_res.dec == '0)
                    begin
                        strobe_next = 1'b1;
                        state_next  = mcdt_pkg::S_IDLE;
                    end
                    else
                    begin
                        state_next = mcdt_pkg::S_SCAN;
                    end
                end
            end

            mcdt_pkg::S_SCAN:
            begin
                // issue the read of the next channel while the previous one is updated
                mem_raddr = iss_reg[IW-1:0];
                if (iss_reg != LAST_ISS)
                begin
                    iss_next      = iss_reg + CW'(1);
                    proc_vld_next = 1'b1;
                    proc_idx_next = iss_reg[IW-1:0];
                end

                if (proc_vld_reg)
                begin
                    if (valid_reg[proc_idx_reg])
                    begin
                        if (mem_rdata <= dec_ext)
                        begin
                            valid_next[proc_idx_reg] = 1'b0;
                            // hold each expiry until the next one shows whether it was the last
                            if (pend_vld_reg)
                            begin
                                strobe_next  = 1'b1;
                                kind_next    = mcdt_pkg::KIND_EXPIRED;
                                channel_next = pend_chan_reg;
                                last_next    = 1'b0;
                            end
                            pend_vld_next  = 1'b1;
                            pend_chan_next = mcdt_pkg::ID_W'(proc_idx_reg) + mcdt_pkg::ID_W'(1);
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = proc_idx_reg;
                            mem_wdata = mem_rdata - dec_ext;
                        end
                    end
                end
                else if (iss_reg == LAST_ISS)
                begin
                    strobe_next = 1'b1;
                    if (pend_vld_reg)
                    begin
                        kind_next    = mcdt_pkg::KIND_EXPIRED;
                        channel_next = pend_chan_reg;
                    end
                    pend_vld_next = 1'b0;
                    state_next    = mcdt_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = mcdt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= mcdt_pkg::S_IDLE;
            valid_reg    <= '0;
            ms_rem_reg   <= '0;
            proc_vld_reg <= 1'b0;
            pend_vld_reg <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            ms_rem_reg   <= ms_rem_next;
            proc_vld_reg <= proc_vld_next;
            pend_vld_reg <= pend_vld_next;
            strobe_reg   <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dec_reg       <= dec_next;
        id_reg        <= id_next;
        iss_reg       <= iss_next;
        proc_idx_reg  <= proc_idx_next;
        pend_chan_reg <= pend_chan_next;
        kind_reg      <= kind_next;
        channel_reg   <= channel_next;
        value_reg     <= value_next;
        last_reg      <= last_next;
    end

    assign busy    = (state_reg != mcdt_pkg::S_IDLE);
    assign strobe  = strobe_reg;
    assign kind    = kind_reg;
    assign channel = channel_reg;
    assign value   = value_reg;
    assign last    = last_reg;

endmodule
